// ===== src/rfcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rectangle fill command sequencer.
// No dependencies; used by rfcs_clip and rect_fill_command_sequencer.
package rfcs_pkg;

  localparam int unsigned MAX_PANEL_DIM = 320;
  localparam int unsigned DIM_W         = 9;
  localparam int unsigned OFS_W         = 7;
  localparam int unsigned CFG_IDX_W     = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 3'd3;

  // request kinds
  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_SLOT = 1'b1;

  // controller command bytes
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        [15:0] fill_value;
  } req_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last_of_fill;
  } res_t;

  // clipped window handed from the clip unit to the sequencer
  typedef struct packed {
    logic             ok;
    logic [15:0]      col_start;
    logic [15:0]      col_end;
    logic [15:0]      row_start;
    logic [15:0]      row_end;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } win_t;

endpackage

// ===== src/rfcs_clip.sv =====
`timescale 1ns / 1ps
// Clips a fill rectangle to the panel and forms the controller window.
// Depends on rfcs_pkg.
module rfcs_clip (
  input  rfcs_pkg::req_t                 req,
  input  logic [rfcs_pkg::DIM_W-1:0]     panel_width,
  input  logic [rfcs_pkg::DIM_W-1:0]     panel_height,
  input  logic [rfcs_pkg::OFS_W-1:0]     column_offset,
  input  logic [rfcs_pkg::OFS_W-1:0]     row_offset,
  output rfcs_pkg::win_t                 win
);

  typedef struct packed {
    logic                       ok;
    logic [15:0]                start_addr;
    logic [15:0]                end_addr;
    logic [rfcs_pkg::DIM_W-1:0] count;
  } axis_t;

  localparam logic [rfcs_pkg::DIM_W-1:0] DIM_MAX = rfcs_pkg::DIM_W'(rfcs_pkg::MAX_PANEL_DIM);

  // one axis: origin check, clip of the span to the panel edge, window addresses
  function automatic axis_t clip_axis(input logic signed [15:0] org,
                                      input logic signed [15:0] len,
                                      input logic [rfcs_pkg::DIM_W-1:0] dim_reg,
                                      input logic [rfcs_pkg::OFS_W-1:0] ofs);
    logic [rfcs_pkg::DIM_W-1:0] dim;
    logic signed [17:0]         sum;
    logic signed [17:0]         dim_s;
    logic signed [17:0]         span;
    logic                       org_ok;
    axis_t                      a;
    dim    = (dim_reg > DIM_MAX) ? DIM_MAX : dim_reg;
    dim_s  = signed'({9'd0, dim});
    org_ok = !org[15] && (org < signed'({7'd0, dim}));
    sum    = 18'(org) + 18'(len);
    span   = (sum > dim_s) ? (dim_s - 18'(org)) : 18'(len);
    a.ok         = org_ok && !span[17] && (span != 18'sd0);
    a.start_addr = org + 16'(ofs);
    a.end_addr   = org + span[15:0] - 16'd1 + 16'(ofs);
    a.count      = span[rfcs_pkg::DIM_W-1:0];
    return a;
  endfunction

  axis_t ax;
  axis_t ay;

  always_comb begin
    ax = clip_axis(req.rect_x, req.rect_w, panel_width, column_offset);
    ay = clip_axis(req.rect_y, req.rect_h, panel_height, row_offset);
    win.ok        = ax.ok && ay.ok;
    win.col_start = ax.start_addr;
    win.col_end   = ax.end_addr;
    win.row_start = ay.start_addr;
    win.row_end   = ay.end_addr;
    win.cols      = ax.count;
    win.rows      = ay.count;
  end

endmodule

// ===== src/rect_fill_command_sequencer.sv =====
`timescale 1ns / 1ps
// Rectangle fill command sequencer: turns fill requests into the byte stream of a
// serial RGB565 display controller. Depends on rfcs_pkg and rfcs_clip.
//
// Usage
//   req channel : one item is either a fill request (req_type 0: rectangle and
//                 colour) or a byte slot (req_type 1) that pulls one link byte.
//   res channel : one item per served byte slot: link byte, data/command level
//                 and a flag on the final pixel low byte of the fill.
//   cfg channel : register writes (panel size, column/row offsets); always ready,
//                 written only while the block is idle: a rule for the user, unenforced.
//   Stream      : column set + 4 bytes, row set + 4 bytes, memory write, then
//                 colour high/low per pixel, row by row.
//   Path        : an accepted item is registered, then worked on; its result is
//                 loaded into the result register when the item advances.
//   Throughput  : one item per cycle unless res stalls; one input register and one
//                 result register, with the clip and byte select between them.
//   Stall       : while res is stalled the result register holds; one more item
//                 may wait in the input register, then req_ready drops.
//   Reset       : rst (synchronous) empties both registers, returns to idle and
//                 loads panel 240 x 240 with zero offsets.
//   Fill requests while a fill runs, rejected fills and byte slots while idle
//   give no result. Clipped-away rectangles are dropped silently.
module rect_fill_command_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  rfcs_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output rfcs_pkg::res_t                    res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfcs_pkg::DIM_W-1:0]        cfg_data
);

  // sequencer phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_CASET = 4'd1;
  localparam logic [3:0] PH_CSH   = 4'd2;
  localparam logic [3:0] PH_CSL   = 4'd3;
  localparam logic [3:0] PH_CEH   = 4'd4;
  localparam logic [3:0] PH_CEL   = 4'd5;
  localparam logic [3:0] PH_RASET = 4'd6;
  localparam logic [3:0] PH_RSH   = 4'd7;
  localparam logic [3:0] PH_RSL   = 4'd8;
  localparam logic [3:0] PH_REH   = 4'd9;
  localparam logic [3:0] PH_REL   = 4'd10;
  localparam logic [3:0] PH_RAMWR = 4'd11;
  localparam logic [3:0] PH_PIXEL = 4'd12;

  // configuration registers
  logic [rfcs_pkg::DIM_W-1:0] panel_width;
  logic [rfcs_pkg::DIM_W-1:0] panel_height;
  logic [rfcs_pkg::OFS_W-1:0] column_offset;
  logic [rfcs_pkg::OFS_W-1:0] row_offset;

  // input register
  logic           req_q_valid;
  rfcs_pkg::req_t req_q;

  // sequencer state
  logic [3:0]                 phase;
  logic [3:0]                 phase_next;
  logic [15:0]                win_col_start;
  logic [15:0]                win_col_end;
  logic [15:0]                win_row_start;
  logic [15:0]                win_row_end;
  logic [15:0]                held_color;
  logic [rfcs_pkg::DIM_W-1:0] cols_left;
  logic [rfcs_pkg::DIM_W-1:0] cols_left_next;
  logic [rfcs_pkg::DIM_W-1:0] rows_left;
  logic [rfcs_pkg::DIM_W-1:0] rows_left_next;
  logic                       low_byte_next;
  logic                       low_byte_next_next;

  logic           advance;
  logic           is_fill;
  logic           emit;
  rfcs_pkg::res_t res_next;
  rfcs_pkg::win_t win;

  logic [rfcs_pkg::DIM_W-1:0] cols_dec;
  logic [rfcs_pkg::DIM_W-1:0] rows_dec;
  logic [15:0]                row_span;

  rfcs_clip u_clip (
    .req           (req_q),
    .panel_width   (panel_width),
    .panel_height  (panel_height),
    .column_offset (column_offset),
    .row_offset    (row_offset),
    .win           (win)
  );

  // the held item moves on when the result register is free or being emptied
  assign advance   = req_q_valid && (!res_valid || res_ready);
  assign req_ready = !req_q_valid || advance;
  assign cfg_ready = 1'b1;
  assign is_fill   = (req_q.req_type == rfcs_pkg::REQ_FILL);
  assign emit      = advance && !is_fill && (phase != PH_IDLE);

  assign cols_dec = cols_left - rfcs_pkg::DIM_W'(1);
  assign rows_dec = rows_left - rfcs_pkg::DIM_W'(1);
  assign row_span = win_col_end - win_col_start + 16'd1;

  // byte select and pixel counting for a served slot
  always_comb begin
    res_next.link_byte    = 8'h00;
    res_next.is_data      = 1'b1;
    res_next.last_of_fill = 1'b0;
    phase_next            = phase;
    cols_left_next        = cols_left;
    rows_left_next        = rows_left;
    low_byte_next_next    = low_byte_next;
    case (phase)
      PH_IDLE: begin
      end
      PH_CASET: begin
        res_next.link_byte = rfcs_pkg::CMD_COLUMN_SET;
        res_next.is_data   = 1'b0;
        phase_next         = PH_CSH;
      end
      PH_CSH: begin
        res_next.link_byte = win_col_start[15:8];
        phase_next         = PH_CSL;
      end
      PH_CSL: begin
        res_next.link_byte = win_col_start[7:0];
        phase_next         = PH_CEH;
      end
      PH_CEH: begin
        res_next.link_byte = win_col_end[15:8];
        phase_next         = PH_CEL;
      end
      PH_CEL: begin
        res_next.link_byte = win_col_end[7:0];
        phase_next         = PH_RASET;
      end
      PH_RASET: begin
        res_next.link_byte = rfcs_pkg::CMD_ROW_SET;
        res_next.is_data   = 1'b0;
        phase_next         = PH_RSH;
      end
      PH_RSH: begin
        res_next.link_byte = win_row_start[15:8];
        phase_next         = PH_RSL;
      end
      PH_RSL: begin
        res_next.link_byte = win_row_start[7:0];
        phase_next         = PH_REH;
      end
      PH_REH: begin
        res_next.link_byte = win_row_end[15:8];
        phase_next         = PH_REL;
      end
      PH_REL: begin
        res_next.link_byte = win_row_end[7:0];
        phase_next         = PH_RAMWR;
      end
      PH_RAMWR: begin
        res_next.link_byte = rfcs_pkg::CMD_MEM_WRITE;
        res_next.is_data   = 1'b0;
        phase_next         = PH_PIXEL;
      end
      default: begin
        // pixel phase: high byte, then low byte and count the pixel
        if (!low_byte_next) begin
          res_next.link_byte = held_color[15:8];
          low_byte_next_next = 1'b1;
        end else begin
          res_next.link_byte = held_color[7:0];
          low_byte_next_next = 1'b0;
          cols_left_next     = cols_dec;
          if (cols_dec == '0) begin
            rows_left_next = rows_dec;
            if (rows_dec == '0) begin
              res_next.last_of_fill = 1'b1;
              phase_next            = PH_IDLE;
            end else begin
              cols_left_next = row_span[rfcs_pkg::DIM_W-1:0];
            end
          end
        end
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= rfcs_pkg::DIM_W'(240);
      panel_height  <= rfcs_pkg::DIM_W'(240);
      column_offset <= '0;
      row_offset    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfcs_pkg::REG_PANEL_WIDTH:   panel_width   <= cfg_data;
        rfcs_pkg::REG_PANEL_HEIGHT:  panel_height  <= cfg_data;
        rfcs_pkg::REG_COLUMN_OFFSET: column_offset <= cfg_data[rfcs_pkg::OFS_W-1:0];
        rfcs_pkg::REG_ROW_OFFSET:    row_offset    <= cfg_data[rfcs_pkg::OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      win_col_start <= '0;
      win_col_end   <= '0;
      win_row_start <= '0;
      win_row_end   <= '0;
      held_color    <= '0;
      cols_left     <= '0;
      rows_left     <= '0;
      low_byte_next <= 1'b0;
    end else if (advance) begin
      if (is_fill) begin
        // new fill only from idle and only if something survives the clip
        if (phase == PH_IDLE && win.ok) begin
          win_col_start <= win.col_start;
          win_col_end   <= win.col_end;
          win_row_start <= win.row_start;
          win_row_end   <= win.row_end;
          held_color    <= req_q.fill_value;
          cols_left     <= win.cols;
          rows_left     <= win.rows;
          low_byte_next <= 1'b0;
          phase         <= PH_CASET;
        end
      end else if (phase != PH_IDLE) begin
        phase         <= phase_next;
        cols_left     <= cols_left_next;
        rows_left     <= rows_left_next;
        low_byte_next <= low_byte_next_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

endmodule
